/* sv/fmpac_pkg.sv */
// ----------------------------------------------------------------------------
// fmpac_pkg
// Shared widths, codes and types of the FM phase accumulator clock.
// ----------------------------------------------------------------------------
package fmpac_pkg;

    // Field widths.
    localparam int BASE_W  = 32;                // base_step register
    localparam int RATIO_W = 16;                // mod_ratio register, Q8.8
    localparam int MOD_W   = 16;                // mod_value input, Q1.15
    localparam int OUT_W   = 32;                // premod_step / phase_step fields

    // Fixed-point arithmetic.
    localparam int FRAC_Q   = 23;               // factor is Q.23
    localparam int ONE_Q8   = 256;              // 1.0 in Q8.8
    localparam int ONE_Q23  = 1 << FRAC_Q;      // 1.0 in Q.23
    localparam int FACT_W   = 32;               // modulation factor width
    localparam int KPROD_W  = (RATIO_W + 1) + (MOD_W + 2);
    localparam int PROD_W   = BASE_W + FACT_W;  // full multiply product
    localparam int MULRES_W = PROD_W - FRAC_Q;  // product after the Q.23 shift
    localparam int QUOT_W   = BASE_W + FRAC_Q;  // dividend and quotient width
    localparam int STEP_W   = QUOT_W;           // widest unsaturated step

    // Serial unit iteration counts.
    localparam int MUL_STEPS = FACT_W;
    localparam int DIV_STEPS = QUOT_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Default phase accumulator width (one turn is 2**PHASE_WIDTH).
    localparam int PHASE_WIDTH_DEF = 32;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = ((MOD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((1 + 2 * OUT_W + 7) / 8) * 8;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_BASE_STEP = 1'b0;
    localparam logic [0:0] REG_MOD_RATIO = 1'b1;
    localparam logic [RATIO_W-1:0] MOD_RATIO_RST = RATIO_W'(ONE_Q8);

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } ser_op_t;

    typedef struct packed {
        logic    start;
        ser_op_t op;
    } ser_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FACTOR,
        ST_LAUNCH,
        ST_RUN,
        ST_DONE
    } fsm_state_t;

    typedef enum logic [1:0] {
        SRC_BASE,
        SRC_MAX,
        SRC_UNIT
    } step_src_t;

endpackage

/* sv/fm_phase_accumulator_clock.sv */
// ----------------------------------------------------------------------------
// fm_phase_accumulator_clock
// Phase-accumulator clock with frequency modulation of the phase step.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  s_*       in         mod_value, signed Q1.15 modulation sample
//  m_*       out        trigger, premod_step, phase_step for that tick
//  APB       in/out     base_step (0x0), mod_ratio (0x4)
//
// Each input beat is one tick. Its step is formed on a shared bit-serial unit
// that handles one bit per clock: 32 iterations for a multiply (mod_value >= 0)
// and 55 for a divide (mod_value < 0). A beat passes through the factor,
// launch, run and done states; the run state is skipped when mod_ratio is zero
// or the divisor is zero and no serial work is done.
// aresetn is synchronous and active low. It restores the registers to their
// reset values and sets the phase to one full turn, so the first tick triggers.
// The result sits in an output register, so the next beat is accepted while
// it waits; a stalled result only holds off the commit of the following tick.
// ----------------------------------------------------------------------------
module fm_phase_accumulator_clock #(
    parameter int PHASE_WIDTH = fmpac_pkg::PHASE_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fmpac_pkg::S_TDATA_W-1:0]   s_tdata,  // [15:0] mod_value
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fmpac_pkg::M_TDATA_W-1:0]   m_tdata,  // [0] trigger,
                                                        // [32:1] premod_step,
                                                        // [64:33] phase_step,
                                                        // [71:65] zero
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fmpac_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [fmpac_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [fmpac_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import fmpac_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [BASE_W-1:0]  base_step_reg;
    logic [RATIO_W-1:0] mod_ratio_reg;
    logic [0:0]         reg_idx;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_step_reg <= '0;
            mod_ratio_reg <= MOD_RATIO_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_BASE_STEP: base_step_reg <= pwdata[BASE_W-1:0];
                REG_MOD_RATIO: mod_ratio_reg <= pwdata[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BASE_STEP: prdata = APB_DATA_W'(base_step_reg);
            REG_MOD_RATIO: prdata = APB_DATA_W'(mod_ratio_reg);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control state machine
    // ------------------------------------------------------------------
    fsm_state_t state_reg, state_next;
    step_src_t  src_reg, src_next;
    ser_req_t   ser_req;
    logic       ser_done;
    logic [STEP_W-1:0] ser_result;
    logic       out_free;
    logic       commit;
    logic       in_accept;

    logic signed [MOD_W-1:0] mod_value_reg;
    logic [FACT_W-1:0]       factor_reg;
    logic                    mod_neg;

    assign mod_neg   = mod_value_reg[MOD_W-1];
    assign out_free  = !m_tvalid || m_tready;
    assign in_accept = s_tvalid && s_tready;

    // Where the step comes from: the plain base step when modulation is off,
    // full scale when a negative input drives the divisor to zero, otherwise
    // the serial unit.
    always_comb begin
        if (mod_ratio_reg == '0) begin
            src_next = SRC_BASE;
        end else if (mod_neg && (factor_reg == '0)) begin
            src_next = SRC_MAX;
        end else begin
            src_next = SRC_UNIT;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) state_next = ST_FACTOR;
            end
            ST_FACTOR: state_next = ST_LAUNCH;
            ST_LAUNCH: begin
                state_next = (src_next == SRC_UNIT) ? ST_RUN : ST_DONE;
            end
            ST_RUN: begin
                if (ser_done) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = (state_reg == ST_IDLE);
        ser_req.start = (state_reg == ST_LAUNCH) && (src_next == SRC_UNIT);
        ser_req.op    = mod_neg ? OP_DIV : OP_MUL;
        commit        = (state_reg == ST_DONE) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        if (state_reg == ST_LAUNCH) begin
            src_reg <= src_next;
        end
    end

    // ------------------------------------------------------------------
    // Modulation factor: f = 1.0 + (mod_ratio - 1.0) * |mod_value|, Q.23
    // ------------------------------------------------------------------
    logic signed [RATIO_W:0]  k_s;
    logic        [MOD_W:0]    m_ext;
    logic        [MOD_W:0]    mag;
    logic signed [KPROD_W-1:0] kprod;
    logic signed [KPROD_W-1:0] fact_s;

    always_comb begin
        k_s    = $signed({1'b0, mod_ratio_reg}) - $signed((RATIO_W + 1)'(ONE_Q8));
        m_ext  = {mod_value_reg[MOD_W-1], mod_value_reg};
        // The most negative input has magnitude exactly 1.0.
        mag    = mod_neg ? (~m_ext + 1'b1) : m_ext;
        kprod  = k_s * $signed({1'b0, mag});
        fact_s = kprod + $signed(KPROD_W'(ONE_Q23));
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            mod_value_reg <= $signed(s_tdata[MOD_W-1:0]);
        end
        if (state_reg == ST_FACTOR) begin
            factor_reg <= fact_s[FACT_W-1:0];
        end
    end

    fmpac_serial u_serial (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (ser_req),
        .operand_a (base_step_reg),
        .operand_b (factor_reg),
        .done      (ser_done),
        .result    (ser_result)
    );

    // ------------------------------------------------------------------
    // Saturation and phase accumulation
    // ------------------------------------------------------------------
    logic [STEP_W-1:0]      step_full;
    logic [PHASE_WIDTH-1:0] step_sat;
    logic [PHASE_WIDTH:0]   phase_reg, phase_sum;
    logic                   wrap;

    always_comb begin
        case (src_reg)
            SRC_BASE: step_full = STEP_W'(base_step_reg);
            SRC_MAX:  step_full = '1;
            SRC_UNIT: step_full = ser_result;
            default:  step_full = '1;
        endcase
        // Steps of a full turn or more clip to just under one turn.
        if (|step_full[STEP_W-1:PHASE_WIDTH]) begin
            step_sat = '1;
        end else begin
            step_sat = step_full[PHASE_WIDTH-1:0];
        end
        // The phase is at most one turn and the step below one turn,
        // so the sum fits in PHASE_WIDTH + 1 bits.
        phase_sum = phase_reg + {1'b0, step_sat};
        wrap      = phase_sum[PHASE_WIDTH];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= {1'b1, {PHASE_WIDTH{1'b0}}};
        end else if (commit) begin
            phase_reg <= {1'b0, phase_sum[PHASE_WIDTH-1:0]};
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic              m_tvalid_reg, m_tvalid_next;
    logic              trigger_reg;
    logic [OUT_W-1:0]  premod_reg;
    logic [OUT_W-1:0]  pstep_reg;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (commit) begin
            trigger_reg <= wrap;
            premod_reg  <= OUT_W'(base_step_reg);
            pstep_reg   <= OUT_W'(step_sat);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({pstep_reg, premod_reg, trigger_reg});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // After any tick the phase lies below one full turn.
    a_phase_below_turn: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> !phase_reg[PHASE_WIDTH])
        else $error("phase left at or above one turn after a tick");

    // One tick at a time: the block leaves idle as soon as a beat is taken.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("second beat accepted while a tick is in progress");

    // The serial unit only finishes while the controller waits for it.
    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_done |-> (state_reg == ST_RUN))
        else $error("serial unit finished outside the run state");

    // A modulated non-negative input always goes through the multiplier.
    a_mul_uses_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LAUNCH) && (mod_ratio_reg != '0) && !mod_neg
        |=> (state_reg == ST_RUN))
        else $error("multiply path skipped the serial unit");

endmodule

/* sv/fmpac_serial.sv */
// ----------------------------------------------------------------------------
// fmpac_serial
// Bit-serial multiply / restoring divide unit, one bit per clock.
// ----------------------------------------------------------------------------
module fmpac_serial (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fmpac_pkg::ser_req_t        req,
    input  logic [fmpac_pkg::BASE_W-1:0] operand_a,   // base step
    input  logic [fmpac_pkg::FACT_W-1:0] operand_b,   // modulation factor
    output logic                       done,
    output logic [fmpac_pkg::STEP_W-1:0] result
);
    import fmpac_pkg::*;

    // rem_reg is the upper accumulator when multiplying and the partial
    // remainder when dividing; dq_reg holds multiplier or dividend bits and
    // collects product or quotient bits as they are formed.
    logic [FACT_W:0]   rem_reg, rem_next;
    logic [QUOT_W-1:0] dq_reg, dq_next;
    logic [FACT_W-1:0] b_reg, b_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    ser_op_t           op_reg, op_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [FACT_W:0]   mul_sum;
    logic [FACT_W:0]   div_shift;
    logic              div_ge;

    always_comb begin
        mul_sum   = rem_reg + (dq_reg[0] ? {1'b0, b_reg} : '0);
        div_shift = {rem_reg[FACT_W-1:0], dq_reg[QUOT_W-1]};
        div_ge    = (div_shift >= {1'b0, b_reg});
    end

    always_comb begin
        rem_next   = rem_reg;
        dq_next    = dq_reg;
        b_next     = b_reg;
        count_next = count_reg;
        op_next    = op_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (req.start) begin
            op_next   = req.op;
            busy_next = 1'b1;
            rem_next  = '0;
            if (req.op == OP_DIV) begin
                b_next     = operand_b;
                dq_next    = {operand_a, {FRAC_Q{1'b0}}};
                count_next = CNT_W'(DIV_STEPS - 1);
            end else begin
                b_next     = operand_a;
                dq_next    = QUOT_W'(operand_b);
                count_next = CNT_W'(MUL_STEPS - 1);
            end
        end else if (busy_reg) begin
            if (op_reg == OP_DIV) begin
                rem_next = div_ge ? (div_shift - {1'b0, b_reg}) : div_shift;
                dq_next  = {dq_reg[QUOT_W-2:0], div_ge};
            end else begin
                rem_next = {1'b0, mul_sum[FACT_W:1]};
                dq_next  = {dq_reg[QUOT_W-1:FACT_W], mul_sum[0], dq_reg[FACT_W-1:1]};
            end
            count_next = count_reg - 1'b1;
            if (count_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg   <= rem_next;
        dq_reg    <= dq_next;
        b_reg     <= b_next;
        count_reg <= count_next;
        op_reg    <= op_next;
    end

    // The product is {rem, low bits}; dropping FRAC_Q bits leaves MULRES_W.
    always_comb begin
        if (op_reg == OP_DIV) begin
            result = dq_reg;
        end else begin
            result = STEP_W'({rem_reg[FACT_W-1:0], dq_reg[FACT_W-1:FRAC_Q]});
        end
    end

    assign done = done_reg;

endmodule

/* verif/fm_phase_accumulator_clock_test.sv */
// ----------------------------------------------------------------------------
// fm_phase_accumulator_clock_test
// Self-checking bench for the FM phase accumulator clock.
// ----------------------------------------------------------------------------
// Modulation samples go in as stream beats and each tick's result beat is
// checked field by field against a cycle-free model of the step arithmetic
// and the phase accumulator. The registers are programmed over the APB port
// and read back, a directed set of ticks covers the corner cases, and then
// several hundred random ticks run under three idling patterns.
// ----------------------------------------------------------------------------
module fm_phase_accumulator_clock_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fmpac_pkg::*;

    // One result beat, unpacked from m_tdata.
    typedef struct packed {
        logic             trigger;
        logic [OUT_W-1:0] premod_step;
        logic [OUT_W-1:0] phase_step;
    } tick_result_t;

    // Model of the block plus the queue of results it still owes us.
    class tick_scoreboard;
        logic [BASE_W-1:0]  base_step_q;
        logic [RATIO_W-1:0] mod_ratio_q;
        logic [32:0]        phase_q;
        tick_result_t       pending_ticks[$];
        int                 errors;

        function new();
            base_step_q = '0;
            mod_ratio_q = MOD_RATIO_RST;
            phase_q     = 33'h1_0000_0000;
            errors      = 0;
        endfunction

        function void set_reg(logic [0:0] index, logic [31:0] value);
            case (index)
                REG_BASE_STEP: begin
                    base_step_q = value;
                end
                REG_MOD_RATIO: begin
                    mod_ratio_q = value[RATIO_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        // Step for one tick: base_step when mod_ratio is zero, else multiply by the
        // Q.23 factor for m >= 0, divide by it for m < 0, then saturate to one turn minus one.
        function logic [OUT_W-1:0] modulated_step(logic signed [MOD_W-1:0] m);
            longint      k;
            longint      mag;
            longint      f;
            logic [63:0] wide;
            if (mod_ratio_q == '0) begin
                wide = 64'(base_step_q);
            end else begin
                k = longint'(mod_ratio_q) - ONE_Q8;
                if (m >= 0) begin
                    f = ONE_Q23 + k * longint'(m);
                    if (f < 0) begin
                        f = 0;
                    end
                    wide = (64'(base_step_q) * 64'(f)) >> FRAC_Q;
                end else begin
                    mag = -longint'(m);
                    f = ONE_Q23 + k * mag;
                    if (f <= 0) begin
                        wide = 64'hFFFF_FFFF;
                    end else begin
                        wide = (64'(base_step_q) << FRAC_Q) / 64'(f);
                    end
                end
            end
            if (wide > 64'hFFFF_FFFF) begin
                wide = 64'hFFFF_FFFF;
            end
            return wide[OUT_W-1:0];
        endfunction

        function void note_tick(logic signed [MOD_W-1:0] m);
            tick_result_t r;
            r.phase_step  = modulated_step(m);
            r.premod_step = base_step_q;
            phase_q       = phase_q + {1'b0, r.phase_step};
            r.trigger     = phase_q[32];
            phase_q[32]   = 1'b0;
            pending_ticks.push_back(r);
        endfunction

        function void check_tick(logic [M_TDATA_W-1:0] tdata);
            tick_result_t want;
            tick_result_t got;
            got.trigger     = tdata[0];
            got.premod_step = tdata[OUT_W:1];
            got.phase_step  = tdata[2*OUT_W:OUT_W+1];
            if (pending_ticks.size() == 0) begin
                $display("%0t: result beat with no tick pending, actual %h", $time, tdata);
                errors++;
                return;
            end
            want = pending_ticks.pop_front();
            if (got.trigger !== want.trigger) begin
                $display("%0t: trigger expected %b actual %b",
                         $time, want.trigger, got.trigger);
                errors++;
            end
            if (got.premod_step !== want.premod_step) begin
                $display("%0t: premod_step expected %h actual %h",
                         $time, want.premod_step, got.premod_step);
                errors++;
            end
            if (got.phase_step !== want.phase_step) begin
                $display("%0t: phase_step expected %h actual %h",
                         $time, want.phase_step, got.phase_step);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;   // [15:0] mod_value
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;   // [0] trigger, [32:1] premod_step,
                                       // [64:33] phase_step, [71:65] zero
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    tick_scoreboard sb;
    int             sender_idle_pct   = 23;
    int             receiver_idle_pct = 70;

    fm_phase_accumulator_clock dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 8 ns clock, low half first.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // The receiver decides on every falling edge whether it takes a beat on
    // the next rising edge, so stalls land on every phase of the block's work.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Every accepted result beat is checked against the oldest pending tick.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_tick(m_tdata);
        end
    end

    // Sends one modulation sample. Called and returning at a falling edge;
    // tvalid stays high across back-to-back beats unless the sender idles.
    task automatic send_tick(input logic signed [MOD_W-1:0] mod_value);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mod_value;
        do @(posedge aclk); while (!s_tready);
        sb.note_tick(mod_value);
        @(negedge aclk);
    endtask

    // Stops the input stream and waits until every pending tick has come out,
    // which leaves the block idle and safe to reprogram.
    task automatic drain_ticks();
        s_tvalid <= 1'b0;
        while (sb.pending_ticks.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // APB write of one register followed by a read back of the same address.
    task automatic write_reg(input logic [0:0] index, input logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] stored;
        stored = (index == REG_MOD_RATIO) ? {16'h0000, value[RATIO_W-1:0]} : value;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(index, value);
        @(negedge aclk);
        // Straight into the setup phase of the read, psel kept high.
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== stored) begin
            $display("%0t: register %0d read back expected %h actual %h",
                     $time, index, stored, readback);
            sb.errors++;
        end
    endtask

    // Programs both registers once the block has gone idle.
    task automatic set_config(input logic [31:0] base, input logic [15:0] ratio);
        drain_ticks();
        write_reg(REG_BASE_STEP, base);
        write_reg(REG_MOD_RATIO, {16'h0000, ratio});
    endtask

    // Random base step, weighted toward the extremes and the wrap-prone range from
    // a quarter to half a turn, with some small steps that make triggers rare.
    function automatic logic [31:0] pick_base();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h0000_0001;
            4: return $urandom_range(32'h00FF_FFFF);
            5: return $urandom_range(32'h8000_0000, 32'h4000_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_ratio();
        case ($urandom_range(6))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'(ONE_Q8);
            3: return 16'hFFFF;
            4: return 16'($urandom_range(512, 128));
            5: return 16'($urandom_range(255, 1));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_mod();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'($urandom_range(511));
            5: return -16'($urandom_range(511));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        sb       = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Register reset values: zero step, and the phase starts at a full
        // turn so the very first tick must trigger.
        send_tick(16'h0000);
        send_tick(16'h7FFF);
        send_tick(16'h8000);

        // Only base_step written, so mod_ratio is still at its reset of 1.0.
        drain_ticks();
        write_reg(REG_BASE_STEP, 32'h4000_0000);
        send_tick(16'h0000);
        send_tick(16'h7FFF);
        send_tick(16'h8000);
        send_tick(16'hFFFF);
        send_tick(16'h0001);

        // Largest ratio and base: the multiply overflows and saturates.
        set_config(32'hFFFF_FFFF, 16'hFFFF);
        send_tick(16'h7FFF);
        send_tick(16'h8000);
        send_tick(16'h0000);
        send_tick(16'hFFFF);

        // Zero ratio: the step is base_step whatever the sample.
        set_config(32'hFFFF_FFFF, 16'h0000);
        send_tick(16'h0005);
        send_tick(16'hFFFB);

        // Smallest nonzero ratio: factor close to zero on either side.
        set_config(32'h8000_0000, 16'h0001);
        send_tick(16'h7FFF);
        send_tick(16'h8000);
        send_tick(16'h0064);

        // Ratio of 2.0 with mid-range samples of both signs.
        set_config(32'h1234_5678, 16'h0200);
        send_tick(16'h4000);
        send_tick(16'hC000);
        send_tick(16'h5555);
        send_tick(16'hAAAA);

        // Random part: three idling patterns, four settings each.
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    sender_idle_pct   = 23;
                    receiver_idle_pct = 70;
                end
                1: begin
                    sender_idle_pct   = 70;
                    receiver_idle_pct = 23;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 4; seg++) begin
                set_config(pick_base(), pick_ratio());
                repeat (58) send_tick(pick_mod());
            end
        end

        // Let the last beats out, then give the block time to show any
        // stray result beat before deciding.
        drain_ticks();
        repeat (64) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog for a hung handshake: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
sv/fmpac_pkg.sv
sv/fmpac_serial.sv
sv/fm_phase_accumulator_clock.sv
verif/fm_phase_accumulator_clock_test.sv
